[rtl/wbps_pkg.sv]
`default_nettype none

package wbps_pkg;

  localparam int unsigned AddrW     = 64;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgMaxLen = 16;
  localparam int unsigned LenW      = 5;

  localparam logic [CfgIndexW-1:0] CFG_PAT_LOW    = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_PAT_HIGH   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_MASK       = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_LENGTH     = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_BASE       = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_REPORT_ALL = 3'd5;

  typedef struct packed {
    logic [63:0]        pattern_high;
    logic [63:0]        pattern_low;
    logic [15:0]        wildcard_mask;
    logic [LenW-1:0]    pat_length;
    logic [AddrW-1:0]   region_base;
    logic               report_all;
  } cfg_t;

  // status of the word held in the window stage
  typedef struct packed {
    logic valid;
    logic last;
    logic overflow;
  } stage_t;

  typedef struct packed {
    logic             match_found;
    logic [AddrW-1:0] match_address;
    logic             scan_done;
  } result_t;

endpackage

`default_nettype wire

[rtl/wbps_window.sv]
`default_nettype none

module wbps_window #(
  parameter int unsigned PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS   = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                accept,
  input  wire logic [7:0]                          data_byte,
  input  wire logic                                last_byte,
  input  wire logic                                advance,
  output wbps_pkg::stage_t                         stage,
  output logic [PATTERN_BYTES-1:0][7:0]            window,
  output logic [OFFSET_BITS:0]                     count
);
  import wbps_pkg::*;

  localparam int unsigned CntW = OFFSET_BITS + 1;

  logic                           restart;
  logic [PATTERN_BYTES-1:0][7:0]  win_base;
  logic [CntW-1:0]                cnt_base;
  logic                           ovf_next;

  // after the last byte of a region the next word starts from a clean window
  always_comb begin
    win_base = restart ? '0 : window;
    cnt_base = restart ? '0 : count;
    ovf_next = (cnt_base == {CntW{1'b1}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b1;
      stage   <= '0;
      window  <= '0;
      count   <= '0;
    end else begin
      if (accept) begin
        window         <= {win_base[PATTERN_BYTES-2:0], data_byte};
        count          <= ovf_next ? cnt_base : cnt_base + CntW'(1);
        stage.last     <= last_byte;
        stage.overflow <= ovf_next;
        restart        <= last_byte;
        stage.valid    <= 1'b1;
      end else if (advance) begin
        stage.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/wbps_match.sv]
`default_nettype none

module wbps_match #(
  parameter int unsigned PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS   = 16
) (
  input  wbps_pkg::cfg_t                       cfg,
  input  wbps_pkg::stage_t                     stage,
  input  wire logic [PATTERN_BYTES-1:0][7:0]   window,
  input  wire logic [OFFSET_BITS:0]            count,
  input  wire logic                            first_reported,
  output logic                                 produce,
  output logic                                 set_first,
  output wbps_pkg::result_t                    result
);
  import wbps_pkg::*;

  localparam int unsigned CntW   = OFFSET_BITS + 1;
  localparam int unsigned IdxW   = $clog2(PATTERN_BYTES);
  localparam int unsigned MaxLen = (PATTERN_BYTES < CfgMaxLen) ? PATTERN_BYTES : CfgMaxLen;

  logic [LenW-1:0]    len;
  logic [MaxLen-1:0]  byte_ok;
  logic [255:0]       pattern;
  logic               in_range;
  logic               match_raw;
  logic               match;
  logic [CntW-1:0]    offset;

  always_comb begin
    if (cfg.pat_length == '0) begin
      len = LenW'(1);
    end else if (cfg.pat_length > LenW'(MaxLen)) begin
      len = LenW'(MaxLen);
    end else begin
      len = cfg.pat_length;
    end
  end

  assign pattern = {128'd0, cfg.pattern_high, cfg.pattern_low};

  // pattern byte i lines up with the window entry len-1-i
  for (genvar i = 0; i < MaxLen; i++) begin : g_cmp
    logic [LenW-1:0] pos;
    assign pos = len - LenW'(1) - LenW'(i);
    assign byte_ok[i] = (LenW'(i) >= len) || cfg.wildcard_mask[i] ||
                        (window[pos[IdxW-1:0]] == pattern[8*i +: 8]);
  end

  always_comb begin
    in_range  = !stage.overflow && (count >= CntW'(len));
    match_raw = in_range && (&byte_ok);
    match     = match_raw && (cfg.report_all || !first_reported);
    set_first = match_raw && !cfg.report_all && !first_reported;
    offset    = count - CntW'(len);
    produce   = stage.valid && (match || stage.last);
    result.match_found   = match;
    result.match_address = match ? cfg.region_base + AddrW'(offset) : '0;
    result.scan_done     = stage.last;
  end

endmodule

`default_nettype wire

[rtl/wildcard_byte_pattern_scanner_core.sv]
`default_nettype none

// channel | dir | tdata                   | tuser          | tlast
// s_*     | in  | [7:0] data byte         | -              | last byte of region
// m_*     | out | [63:0] match address    | [0] match found| scan done
// cfg_*   | in  | write enable, index, 64-bit data, no read-back
//
// one byte per cycle while s_tready is high: a word sits in the window stage, where
// the masked compare runs, then lands in the output register.
// a byte that neither completes a reportable match nor ends the region
// gives no output word.
// rst is synchronous and returns config, window and counters to start state.
// when the output holds a word that m_tready does not take and the byte in the
// window stage also makes a word, the stage holds it and s_tready drops; an
// empty window stage still takes a byte.

module wildcard_byte_pattern_scanner_core #(
  parameter int unsigned PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [wbps_pkg::AddrW-1:0]             m_tdata,   // [63:0] match_address
  output logic [0:0]                             m_tuser,   // [0] match_found
  output logic                                   m_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [wbps_pkg::CfgIndexW-1:0]    cfg_index,
  input  wire logic [wbps_pkg::CfgDataW-1:0]     cfg_data
);
  import wbps_pkg::*;

  cfg_t                           cfg;
  stage_t                         stage;
  logic [PATTERN_BYTES-1:0][7:0]  window;
  logic [OFFSET_BITS:0]           count;
  logic                           first_reported;
  logic                           produce;
  logic                           set_first;
  result_t                        result;
  logic                           accept;
  logic                           out_free;
  logic                           advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.wildcard_mask  <= '0;
      cfg.pat_length     <= LenW'(1);
      cfg.region_base    <= '0;
      cfg.report_all     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_LOW:    cfg.pattern_low    <= cfg_data;
        CFG_PAT_HIGH:   cfg.pattern_high   <= cfg_data;
        CFG_MASK:       cfg.wildcard_mask  <= cfg_data[15:0];
        CFG_LENGTH:     cfg.pat_length     <= cfg_data[LenW-1:0];
        CFG_BASE:       cfg.region_base    <= cfg_data[AddrW-1:0];
        CFG_REPORT_ALL: cfg.report_all     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign advance  = stage.valid && (!produce || out_free);
  assign s_tready = !stage.valid || advance;
  assign accept   = s_tvalid && s_tready;

  wbps_window #(
    .PATTERN_BYTES(PATTERN_BYTES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_byte(s_tdata),
    .last_byte(s_tlast),
    .advance  (advance),
    .stage    (stage),
    .window   (window),
    .count    (count)
  );

  wbps_match #(
    .PATTERN_BYTES(PATTERN_BYTES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_match (
    .cfg           (cfg),
    .stage         (stage),
    .window        (window),
    .count         (count),
    .first_reported(first_reported),
    .produce       (produce),
    .set_first     (set_first),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_reported <= 1'b0;
    end else if (advance) begin
      if (stage.last) begin
        first_reported <= 1'b0;
      end else if (set_first) begin
        first_reported <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && produce) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      m_tdata    <= result.match_address;
      m_tuser[0] <= result.match_found;
      m_tlast    <= result.scan_done;
    end
  end

  // a word without a match only ever closes a region
  a_nomatch_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("output word with no match and no scan done");

  a_nomatch_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("nonzero address on word without match");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> stage.valid && produce && !out_free)
    else $error("input stalled without a blocked window stage");

  a_first_only: assert property (@(posedge clk) disable iff (rst)
    advance && set_first && !stage.last |=> first_reported)
    else $error("first match not recorded");

endmodule

`default_nettype wire

[tb/tb_top.sv]
module tb_top;
  import wbps_pkg::*;

  localparam int unsigned CountMax = (1 << 17) - 1;
  localparam logic [CfgIndexW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CfgIndexW-1:0] CFG_SPARE_B = 3'd7;
  localparam int HoldCycles  = 500;
  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 6;
  localparam int RandomItems = 600;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [AddrW-1:0]     m_tdata;
  logic [0:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  wildcard_byte_pattern_scanner_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // scanner copy: registers and per-region state
  logic [63:0] pat_low, pat_high, base_addr;
  logic [15:0] wild_mask;
  logic [4:0]  pat_len;
  logic        every_match;
  logic [7:0]  window [16];
  logic [16:0] seen_count;
  logic        first_done;

  result_t pending_results [$];
  int      fail_count   = 0;
  int      quiet_cycles = 0;
  bit      src_idle_en  = 1'b1;
  bit      sink_idle_en = 1'b1;
  bit      hold_req     = 1'b0;

  function automatic int unsigned eff_len();
    int unsigned n = pat_len;
    if (n == 0) n = 1;
    if (n > CfgMaxLen) n = CfgMaxLen;
    return n;
  endfunction

  function automatic void restart_region();
    for (int i = 0; i < 16; i++) window[i] = 8'h00;
    seen_count = '0;
    first_done = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic l);
    int unsigned len;
    logic        ovf, hit;
    logic [63:0] offset;
    logic [127:0] pat;
    result_t     item;
    len = eff_len();
    pat = {pat_high, pat_low};
    ovf = (seen_count == 17'(CountMax));
    for (int i = 15; i > 0; i--) window[i] = window[i-1];
    window[0] = b;
    if (!ovf) seen_count++;
    hit = 1'b0;
    offset = '0;
    if (!ovf && seen_count >= len) begin
      hit = 1'b1;
      // pattern byte 0 lines up with the oldest byte of the compared span
      for (int i = 0; i < len; i++)
        if (!wild_mask[i] && window[len-1-i] != pat[8*i +: 8]) hit = 1'b0;
      offset = 64'(seen_count) - 64'(len);
    end
    if (hit && !every_match) begin
      if (first_done) hit = 1'b0;
      else first_done = 1'b1;
    end
    if (hit || l) begin
      item = {hit, hit ? base_addr + offset : 64'h0, l};
      pending_results.insert(pending_results.size(), item);
    end
    if (l) restart_region();
  endfunction

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PAT_LOW:    pat_low     = value;
      CFG_PAT_HIGH:   pat_high    = value;
      CFG_MASK:       wild_mask   = value[15:0];
      CFG_LENGTH:     pat_len     = value[4:0];
      CFG_BASE:       base_addr   = value;
      CFG_REPORT_ALL: every_match = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // valid stays high after a word so a back-to-back word needs no toggle
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    scan_byte(b, l);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_word
    result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tdata, m_tlast};
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word: expected none, actual found %b addr %h done %b",
                 $time, got.match_found, got.match_address, got.scan_done);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          $display("%0t: expected found %b addr %h done %b, actual found %b addr %h done %b",
                   $time, want.match_found, want.match_address, want.scan_done,
                   got.match_found, got.match_address, got.scan_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("wildcard_byte_pattern_scanner_core: mismatch");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = sink_idle_en ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready) && !hold_req);
    end
  end

  // register values straight out of reset: pattern 00, length 1, first only
  task automatic test_reset_state();
    settle();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_window_rules();
    settle();
    write_reg(CFG_PAT_LOW, 64'h0000_0000_00AA_0000);
    write_reg(CFG_PAT_HIGH, 64'h0);
    write_reg(CFG_MASK, 64'h0);
    write_reg(CFG_LENGTH, 64'd3);
    write_reg(CFG_BASE, '1);
    write_reg(CFG_REPORT_ALL, 64'd1);
    // zeroed window looks like the pattern but the region is too short
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    settle();
    // second byte wild: overlapping matches after every ff
    write_reg(CFG_PAT_LOW, 64'h0000_0000_0000_00FF);
    write_reg(CFG_MASK, 64'h0002);
    write_reg(CFG_LENGTH, 64'd2);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_length_limits();
    logic [127:0] pat;
    settle();
    // upper data bits must be dropped; length 0 acts as 1
    write_reg(CFG_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
    write_reg(CFG_PAT_LOW, 64'h5C);
    write_reg(CFG_MASK, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(CFG_REPORT_ALL, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(CFG_BASE, {$urandom, $urandom});
    send_byte(8'h7E, 1'b0);
    send_byte(8'h5C, 1'b1);
    settle();
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, {$urandom, $urandom});
    write_reg(CFG_PAT_LOW, {$urandom, $urandom});
    write_reg(CFG_PAT_HIGH, {$urandom, $urandom});
    write_reg(CFG_MASK, 64'h5555);
    write_reg(CFG_LENGTH, 64'h1F);
    pat = {pat_high, pat_low};
    for (int i = 0; i < CfgMaxLen; i++)
      send_byte(wild_mask[i] ? 8'($urandom) : pat[8*i +: 8], i == CfgMaxLen - 1);
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(CFG_MASK, 64'hFFFF);
    write_reg(CFG_LENGTH, 64'd1);
    write_reg(CFG_REPORT_ALL, 64'd1);
    src_idle_en = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom), i == 39);
    settle();
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_regions();
    int         sent, budget, cut, part;
    int unsigned plen;
    logic [7:0] region [$];
    logic [127:0] pat;
    bit         ends;
    sent = 0;
    while (sent < RandomItems) begin
      settle();
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      write_reg(CFG_PAT_LOW, {$urandom, $urandom});
      write_reg(CFG_PAT_HIGH, {$urandom, $urandom});
      case ($urandom_range(0, 3))
        0: write_reg(CFG_MASK, {$urandom, 16'($urandom), 16'h0000});
        1: write_reg(CFG_MASK, {$urandom, 16'($urandom), 16'hFFFF});
        default: write_reg(CFG_MASK, {$urandom, 16'($urandom), 16'($urandom & $urandom)});
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(CFG_LENGTH, {$urandom, 27'($urandom), 5'd0});
        1: write_reg(CFG_LENGTH, {$urandom, 27'($urandom), 5'd16});
        2: write_reg(CFG_LENGTH, {$urandom, 27'($urandom), 5'($urandom_range(17, 31))});
        default: write_reg(CFG_LENGTH, {$urandom, 27'($urandom), 5'($urandom_range(1, 8))});
      endcase
      case ($urandom_range(0, 2))
        0: write_reg(CFG_BASE, 64'h0);
        1: write_reg(CFG_BASE, '1);
        default: write_reg(CFG_BASE, {$urandom, $urandom});
      endcase
      write_reg(CFG_REPORT_ALL, {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
      pat  = {pat_high, pat_low};
      plen = eff_len();
      budget = $urandom_range(30, 70);
      while (budget > 0) begin
        region = {};
        cut = $urandom_range(1, 40);
        while (region.size() < cut) begin
          case ($urandom_range(0, 5))
            0, 1, 2: begin
              for (int i = 0; i < plen; i++)
                region.insert(region.size(), wild_mask[i] ? 8'($urandom) : pat[8*i +: 8]);
            end
            3: begin
              // pattern cut short, then a stray byte
              part = $urandom_range(1, plen);
              for (int i = 0; i < part; i++)
                region.insert(region.size(), wild_mask[i] ? 8'($urandom) : pat[8*i +: 8]);
              region.insert(region.size(), 8'($urandom));
            end
            default: region.insert(region.size(), 8'($urandom));
          endcase
        end
        // now and then leave the region open across the next settings
        ends = ($urandom_range(0, 5) != 0);
        for (int i = 0; i < region.size(); i++)
          send_byte(region[i], ends && (i == region.size() - 1));
        sent   += region.size();
        budget -= region.size();
      end
    end
  endtask

  initial begin
    pat_low     = '0;
    pat_high    = '0;
    wild_mask   = '0;
    pat_len     = 5'd1;
    base_addr   = '0;
    every_match = 1'b0;
    restart_region();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_window_rules();
    test_length_limits();
    test_backpressure();
    test_random_regions();
    settle();
    if (fail_count == 0) begin
      $display("wildcard_byte_pattern_scanner_core: match");
    end else begin
      $display("wildcard_byte_pattern_scanner_core: mismatch");
    end
    $finish;
  end

endmodule

[wildcard_byte_pattern_scanner_core.f]
rtl/wbps_pkg.sv
rtl/wbps_window.sv
rtl/wbps_match.sv
rtl/wildcard_byte_pattern_scanner_core.sv
tb/tb_top.sv
